// ===== src/alu_wcf_pkg.sv =====
// Package with the opcodes, the flag type and the flag reset value of the ALU.
`timescale 1ns / 1ps

package alu_wcf_pkg;

  localparam int unsigned DataW = 32;

  typedef logic [DataW-1:0] word_t;
  typedef logic [3:0]       opcode_t;

  localparam opcode_t OP_AND  = 4'h0;
  localparam opcode_t OP_XOR  = 4'h1;
  localparam opcode_t OP_SUB  = 4'h2;
  localparam opcode_t OP_RSB  = 4'h3;
  localparam opcode_t OP_ADD  = 4'h4;
  localparam opcode_t OP_ADC  = 4'h5;
  localparam opcode_t OP_SBC  = 4'h6;
  localparam opcode_t OP_RSC  = 4'h7;
  localparam opcode_t OP_TST  = 4'h8;
  localparam opcode_t OP_TEQ  = 4'h9;
  localparam opcode_t OP_CMP  = 4'ha;
  localparam opcode_t OP_CMN  = 4'hb;
  localparam opcode_t OP_ORR  = 4'hc;
  localparam opcode_t OP_MOV  = 4'hd;
  localparam opcode_t OP_BIC  = 4'he;
  localparam opcode_t OP_MVN  = 4'hf;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{n: 1'b0, z: 1'b0, c: 1'b0, v: 1'b0};

endpackage

// ===== src/alu_wcf_core.sv =====
// Combinational datapath: one shared adder, the logic unit and the flag update.
`timescale 1ns / 1ps

module alu_wcf_core (
  input  alu_wcf_pkg::opcode_t op,
  input  alu_wcf_pkg::word_t   a,
  input  alu_wcf_pkg::word_t   b,
  input  logic                 set_flags,
  input  alu_wcf_pkg::flags_t  flags_cur,
  output alu_wcf_pkg::word_t   result,
  output alu_wcf_pkg::flags_t  flags_new
);

  alu_wcf_pkg::word_t          add_x;
  alu_wcf_pkg::word_t          add_y;
  logic                        add_cin;
  logic [alu_wcf_pkg::DataW:0] sum;
  alu_wcf_pkg::word_t          sum_r;
  logic                        sum_v;
  logic                        arith;
  logic                        write_flags;

  // Every arithmetic opcode maps onto x + y + cin, subtracts using ~y.
  always_comb begin
    add_x   = a;
    add_y   = b;
    add_cin = 1'b0;
    arith   = 1'b1;
    case (op)
      alu_wcf_pkg::OP_SUB, alu_wcf_pkg::OP_CMP: begin
        add_y   = ~b;
        add_cin = 1'b1;
      end
      alu_wcf_pkg::OP_RSB: begin
        add_x   = b;
        add_y   = ~a;
        add_cin = 1'b1;
      end
      alu_wcf_pkg::OP_ADD, alu_wcf_pkg::OP_CMN: begin
        add_cin = 1'b0;
      end
      alu_wcf_pkg::OP_ADC: begin
        add_cin = flags_cur.c;
      end
      alu_wcf_pkg::OP_SBC: begin
        add_y   = ~b;
        add_cin = flags_cur.c;
      end
      alu_wcf_pkg::OP_RSC: begin
        add_x   = b;
        add_y   = ~a;
        add_cin = flags_cur.c;
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y}
               + {{alu_wcf_pkg::DataW{1'b0}}, add_cin};
  assign sum_r = sum[alu_wcf_pkg::DataW-1:0];
  assign sum_v = ((add_x[alu_wcf_pkg::DataW-1] ^ sum_r[alu_wcf_pkg::DataW-1])
               & (add_y[alu_wcf_pkg::DataW-1] ^ sum_r[alu_wcf_pkg::DataW-1]));

  always_comb begin
    case (op)
      alu_wcf_pkg::OP_AND, alu_wcf_pkg::OP_TST: result = a & b;
      alu_wcf_pkg::OP_XOR, alu_wcf_pkg::OP_TEQ: result = a ^ b;
      alu_wcf_pkg::OP_ORR:                      result = a | b;
      alu_wcf_pkg::OP_MOV:                      result = b;
      alu_wcf_pkg::OP_BIC:                      result = a & ~b;
      alu_wcf_pkg::OP_MVN:                      result = ~b;
      default:                                  result = sum_r;
    endcase
  end

  // Moves never touch the flags; logical operations keep C and V.
  assign write_flags = set_flags && (op != alu_wcf_pkg::OP_MOV)
                       && (op != alu_wcf_pkg::OP_MVN);

  always_comb begin
    flags_new = flags_cur;
    if (write_flags) begin
      flags_new.n = result[alu_wcf_pkg::DataW-1];
      flags_new.z = (result == '0);
      if (arith) begin
        flags_new.c = sum[alu_wcf_pkg::DataW];
        flags_new.v = sum_v;
      end
    end
  end

endmodule

// ===== src/alu_with_condition_flags.sv =====
// Top level of the ALU: input register, datapath, flag register and result register.
//
//   Channel | Direction | Ports                                        | Handshake
//   in_     | input     | bubble, opcode, operands, set_flags          | in_valid / in_stall
//   out_    | output    | alu_result, negative/zero/carry/overflow     | out_valid / out_stall
//
// One item per cycle is sustained while out_stall is low; a taken item goes into the input
// register, then through the adder and flag logic into the result register.
// The flag register closes a loop around the datapath, so adc/sbc/rsc see the flags of the item just before.
// Bubble items are taken and dropped at the input and give no result.
// Reset (rst_n low, synchronous) empties both stages and clears the flag register.
// A stalled result holds; the input register keeps taking items until it is full too.
`timescale 1ns / 1ps

module alu_with_condition_flags (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_bubble,
  input  alu_wcf_pkg::opcode_t in_opcode,
  input  alu_wcf_pkg::word_t   in_first_operand,
  input  alu_wcf_pkg::word_t   in_second_operand,
  input  logic                 in_set_flags,
  output logic                 out_valid,
  input  logic                 out_stall,
  output alu_wcf_pkg::word_t   out_alu_result,
  output logic                 out_negative_flag,
  output logic                 out_zero_flag,
  output logic                 out_carry_flag,
  output logic                 out_overflow_flag
);

  logic                 s1_valid_r, s1_valid_nxt;
  alu_wcf_pkg::opcode_t s1_op_r;
  alu_wcf_pkg::word_t   s1_a_r;
  alu_wcf_pkg::word_t   s1_b_r;
  logic                 s1_set_r;
  logic                 out_valid_r, out_valid_nxt;
  alu_wcf_pkg::word_t   out_result_r;
  alu_wcf_pkg::flags_t  out_flags_r;
  alu_wcf_pkg::flags_t  flags_r, flags_nxt;
  alu_wcf_pkg::word_t   core_result;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;

  alu_wcf_core u_core (
    .op        (s1_op_r),
    .a         (s1_a_r),
    .b         (s1_b_r),
    .set_flags (s1_set_r),
    .flags_cur (flags_r),
    .result    (core_result),
    .flags_new (flags_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall && !in_bubble;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= alu_wcf_pkg::FLAGS_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= in_opcode;
      s1_a_r   <= in_first_operand;
      s1_b_r   <= in_second_operand;
      s1_set_r <= in_set_flags;
    end
    if (advance) begin
      out_result_r <= core_result;
      out_flags_r  <= flags_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alu_result    = out_result_r;
  assign out_negative_flag = out_flags_r.n;
  assign out_zero_flag     = out_flags_r.z;
  assign out_carry_flag    = out_flags_r.c;
  assign out_overflow_flag = out_flags_r.v;

endmodule

// ===== src/alu_wcf_checker.sv =====
// Port-level checker for the ALU and the bind that attaches it.
`timescale 1ns / 1ps

module alu_wcf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_bubble,
  input logic                 out_valid,
  input logic                 out_stall,
  input alu_wcf_pkg::word_t   out_alu_result,
  input logic                 out_negative_flag,
  input logic                 out_zero_flag
);

  // The input side only backs up when a result is waiting and held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised without a held result");

  // A real item that is taken reaches the output once out_stall is low while it waits in the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_bubble) ##1 !out_stall |=> out_valid)
    else $error("item did not reach the output in time");

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_alu_result)
                                  && $stable(out_negative_flag) && $stable(out_zero_flag)))
    else $error("held result changed");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind alu_with_condition_flags alu_wcf_checker u_alu_wcf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_bubble         (in_bubble),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_alu_result    (out_alu_result),
  .out_negative_flag (out_negative_flag),
  .out_zero_flag     (out_zero_flag)
);
